>>> hw/rtl/ecrv_pkg.sv
// shared types, constants and register codes of the echo / reverb delay line
package ecrv_pkg;

    // delay line geometry and number format
    localparam int DELAY_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(DELAY_DEPTH);
    localparam int FRACTION_BITS = 16;
    localparam int SAMPLE_W      = 32;
    localparam int GAIN_W        = 16;
    localparam int OUT_W         = FRACTION_BITS + 2;
    localparam int NUM_TAPS      = 4;

    // tap distances, in items back from the write pointer
    // each must be longer than the pipeline from read issue to line write
    localparam int TAP_ONE_DISTANCE   = 701;
    localparam int TAP_TWO_DISTANCE   = 1451;
    localparam int TAP_THREE_DISTANCE = 2203;
    localparam int TAP_FOUR_DISTANCE  = 3119;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [GAIN_W-1:0]     t_gain;
    typedef logic [OUT_W-1:0]      t_out;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // distances reduced modulo the depth, and the matching wrap offsets
    localparam t_addr TAP_DIST [NUM_TAPS] = '{
        t_addr'(TAP_ONE_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_TWO_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_THREE_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_FOUR_DISTANCE % DELAY_DEPTH)
    };
    localparam t_addr TAP_WRAP [NUM_TAPS] = '{
        t_addr'(DELAY_DEPTH - (TAP_ONE_DISTANCE % DELAY_DEPTH)),
        t_addr'(DELAY_DEPTH - (TAP_TWO_DISTANCE % DELAY_DEPTH)),
        t_addr'(DELAY_DEPTH - (TAP_THREE_DISTANCE % DELAY_DEPTH)),
        t_addr'(DELAY_DEPTH - (TAP_FOUR_DISTANCE % DELAY_DEPTH))
    };
    localparam t_addr LAST_ADDR = t_addr'(DELAY_DEPTH - 1);

    // output clamp limits, plus and minus one
    localparam t_sample UNITY     = t_sample'(64'd1 << FRACTION_BITS);
    localparam t_sample NEG_UNITY = t_sample'(-(64'sd1 << FRACTION_BITS));
    localparam logic signed [OUT_W-1:0] OUT_MAX = t_out'(64'd1 << FRACTION_BITS);
    localparam logic signed [OUT_W-1:0] OUT_MIN = t_out'(-(64'sd1 << FRACTION_BITS));

    // register indexes
    localparam t_cfg_idx REG_MODE        = t_cfg_idx'(0);
    localparam t_cfg_idx REG_ECHO_WET    = t_cfg_idx'(1);
    localparam t_cfg_idx REG_ECHO_FB     = t_cfg_idx'(2);
    localparam t_cfg_idx REG_TAP_ONE     = t_cfg_idx'(3);
    localparam t_cfg_idx REG_TAP_TWO     = t_cfg_idx'(4);
    localparam t_cfg_idx REG_TAP_THREE   = t_cfg_idx'(5);
    localparam t_cfg_idx REG_TAP_FOUR    = t_cfg_idx'(6);
    localparam t_cfg_idx REG_REVERB_FB   = t_cfg_idx'(7);

    // mode codes
    localparam logic MODE_ECHO   = 1'b0;
    localparam logic MODE_REVERB = 1'b1;

    // register reset values
    localparam t_gain RST_ECHO_WET   = t_gain'(49152);
    localparam t_gain RST_ECHO_FB    = t_gain'(36044);
    localparam t_gain RST_TAP_ONE    = t_gain'(36044);
    localparam t_gain RST_TAP_TWO    = t_gain'(26214);
    localparam t_gain RST_TAP_THREE  = t_gain'(18350);
    localparam t_gain RST_TAP_FOUR   = t_gain'(13107);
    localparam t_gain RST_REVERB_FB  = t_gain'(22937);

endpackage

>>> hw/rtl/ecrv_ram.sv
// simple dual read port ram with one write port and registered read data
module ecrv_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/ecrv_gain.sv
// registered q0.16 gain product: signed sample times unsigned gain, floor shift
module ecrv_gain
    import ecrv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sample i_value,
    input  t_gain   i_gain,
    output t_sample o_prod
);

    logic signed [SAMPLE_W+GAIN_W:0] w_full;
    t_sample                         r_prod;

    assign w_full = $signed(i_value) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[SAMPLE_W+GAIN_W-1:GAIN_W];
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/ecrv_outq.sv
// two entry output queue, decouples the pipeline from the result channel
module ecrv_outq
    import ecrv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_out       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/echo_reverb_delay_line.sv
// top level of the echo / reverb delay line: feedback comb echo and four tap reverb
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   i_sample_in (q16.16, 32 bit)
//   out      source     o_out_valid / i_out_ready o_sample_out (q2.16, 18 bit)
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one sample per cycle sustained while the result queue has room; the stages from input
// transfer to the result queue are the line read, operand select, gain multiply, two
// add stages and the feedback multiply ahead of the line write
// reset (synchronous, active low) zeroes the write pointer and the line-filled
// flag; entries never written read as zero, so the line needs no clearing pass
// a full two entry result queue stalls every stage at once; nothing is lost
module echo_reverb_delay_line
    import ecrv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample input
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    // sample output
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_sample_out,
    // register writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_idx                i_cfg_index,
    input  t_cfg_data               i_cfg_data
);

    localparam int NUM_STAGES = 6;

    // configuration registers
    logic    r_mode;
    t_gain   r_wet_gain;
    t_gain   r_efb_gain;
    t_gain   r_tap_gain [NUM_TAPS];
    t_gain   r_rfb_gain;

    // write pointer and line-filled flag (set once the pointer has wrapped)
    t_addr   r_wp;
    t_addr   n_wp;
    logic    r_filled;

    // pipeline control
    logic [NUM_STAGES-1:0] r_v;
    logic    w_en;
    logic    w_in_acc;
    logic    w_q_full;
    logic    w_push;

    // read issue
    t_addr   w_tap_addr [NUM_TAPS];
    logic    w_tap_ok   [NUM_TAPS];
    t_addr   w_addr0;
    logic    w_ok0;
    t_sample w_rd [NUM_TAPS];

    // stage 1: line data arrives from the rams
    t_sample r1_x;
    logic    r1_mode;
    t_addr   r1_wp;
    logic    r1_ok [NUM_TAPS];

    // stage 2: masked operands and their gains
    t_sample w_opd  [NUM_TAPS];
    t_gain   w_gain [NUM_TAPS];
    t_sample r2_opd  [NUM_TAPS];
    t_gain   r2_gain [NUM_TAPS];
    t_sample r2_x;
    logic    r2_mode;
    t_addr   r2_wp;

    // stage 3: gain products
    t_sample w_prod [NUM_TAPS];
    t_sample r3_x;
    logic    r3_mode;
    t_addr   r3_wp;

    // stage 4: partial sums
    t_sample r4_a;
    t_sample r4_b;
    t_sample r4_c;
    t_sample r4_x;
    logic    r4_mode;
    t_addr   r4_wp;

    // stage 5: mix (echo: dry plus wet) and echo store value
    t_sample r5_mix;
    t_sample r5_echo_st;
    t_sample r5_x;
    logic    r5_mode;
    t_addr   r5_wp;

    // stage 6: feedback product, line write and clamp
    t_sample w_fb_prod;
    t_sample r6_mix;
    t_sample r6_echo_st;
    t_sample r6_x;
    logic    r6_mode;
    t_addr   r6_wp;
    t_sample w_store;
    t_out    w_clamped;
    t_out    w_q_data;

    assign o_cfg_ready = 1'b1;

    // configuration writes, index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ECHO;
            r_wet_gain    <= RST_ECHO_WET;
            r_efb_gain    <= RST_ECHO_FB;
            r_tap_gain[0] <= RST_TAP_ONE;
            r_tap_gain[1] <= RST_TAP_TWO;
            r_tap_gain[2] <= RST_TAP_THREE;
            r_tap_gain[3] <= RST_TAP_FOUR;
            r_rfb_gain    <= RST_REVERB_FB;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:      r_mode        <= i_cfg_data[0];
                REG_ECHO_WET:  r_wet_gain    <= i_cfg_data;
                REG_ECHO_FB:   r_efb_gain    <= i_cfg_data;
                REG_TAP_ONE:   r_tap_gain[0] <= i_cfg_data;
                REG_TAP_TWO:   r_tap_gain[1] <= i_cfg_data;
                REG_TAP_THREE: r_tap_gain[2] <= i_cfg_data;
                REG_TAP_FOUR:  r_tap_gain[3] <= i_cfg_data;
                REG_REVERB_FB: r_rfb_gain    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // whole pipeline moves unless the result queue is full
    assign w_en       = !w_q_full;
    assign o_in_ready = w_en;
    assign w_in_acc   = i_in_valid && w_en;
    assign w_push     = w_en && r_v[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NUM_STAGES-2:0], w_in_acc};
        end
    end

    // write pointer wraps at the line depth
    assign n_wp = (r_wp == LAST_ADDR) ? '0 : r_wp + t_addr'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_filled <= 1'b0;
        end else if (w_in_acc) begin
            r_wp <= n_wp;
            if (r_wp == LAST_ADDR) begin
                r_filled <= 1'b1;
            end
        end
    end

    // tap addresses; an entry is written already once the line has wrapped,
    // or when the tap lies behind the pointer without wrapping around
    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            if (r_wp >= TAP_DIST[k]) begin
                w_tap_addr[k] = r_wp - TAP_DIST[k];
            end else begin
                w_tap_addr[k] = r_wp + TAP_WRAP[k];
            end
            w_tap_ok[k] = r_filled || ((TAP_DIST[k] != '0) && (r_wp >= TAP_DIST[k]));
        end
    end

    // echo reads the entry under the pointer, one full line back
    assign w_addr0 = (r_mode == MODE_REVERB) ? w_tap_addr[0] : r_wp;
    assign w_ok0   = (r_mode == MODE_REVERB) ? w_tap_ok[0]   : r_filled;

    // two copies of the line, two read ports each, same writes
    ecrv_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (w_push),
        .i_waddr   (r6_wp),
        .i_wdata   (w_store),
        .i_re      (w_en),
        .i_raddr_a (w_addr0),
        .i_raddr_b (w_tap_addr[1]),
        .o_rdata_a (w_rd[0]),
        .o_rdata_b (w_rd[1])
    );

    ecrv_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (w_push),
        .i_waddr   (r6_wp),
        .i_wdata   (w_store),
        .i_re      (w_en),
        .i_raddr_a (w_tap_addr[2]),
        .i_raddr_b (w_tap_addr[3]),
        .o_rdata_a (w_rd[2]),
        .o_rdata_b (w_rd[3])
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x     <= i_sample_in;
            r1_mode  <= r_mode;
            r1_wp    <= r_wp;
            r1_ok[0] <= w_ok0;
            r1_ok[1] <= w_tap_ok[1];
            r1_ok[2] <= w_tap_ok[2];
            r1_ok[3] <= w_tap_ok[3];
        end
    end

    // operand select: echo uses lane 0 for wet and lane 1 for feedback
    always_comb begin
        if (r1_mode == MODE_REVERB) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                w_opd[k]  = r1_ok[k] ? w_rd[k] : '0;
                w_gain[k] = r_tap_gain[k];
            end
        end else begin
            w_opd[0]  = r1_ok[0] ? w_rd[0] : '0;
            w_opd[1]  = r1_ok[0] ? w_rd[0] : '0;
            w_opd[2]  = '0;
            w_opd[3]  = '0;
            w_gain[0] = r_wet_gain;
            w_gain[1] = r_efb_gain;
            w_gain[2] = r_tap_gain[2];
            w_gain[3] = r_tap_gain[3];
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_opd  <= w_opd;
            r2_gain <= w_gain;
            r2_x    <= r1_x;
            r2_mode <= r1_mode;
            r2_wp   <= r1_wp;
        end
    end

    // stage 3: four gain multipliers
    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_lane
        ecrv_gain u_gain (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_value (r2_opd[g]),
            .i_gain  (r2_gain[g]),
            .o_prod  (w_prod[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_x    <= r2_x;
            r3_mode <= r2_mode;
            r3_wp   <= r2_wp;
        end
    end

    // stage 4: sums wrap modulo 2^32
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_a    <= r3_x + w_prod[0];
            r4_b    <= (r3_mode == MODE_REVERB) ? w_prod[1] + w_prod[2]
                                                : r3_x + w_prod[1];
            r4_c    <= w_prod[3];
            r4_x    <= r3_x;
            r4_mode <= r3_mode;
            r4_wp   <= r3_wp;
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_mix     <= (r4_mode == MODE_REVERB) ? r4_a + r4_b + r4_c : r4_a;
            r5_echo_st <= r4_b;
            r5_x       <= r4_x;
            r5_mode    <= r4_mode;
            r5_wp      <= r4_wp;
        end
    end

    // stage 6: reverb feedback of the mix
    ecrv_gain u_fb_gain (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (r5_mix),
        .i_gain  (r_rfb_gain),
        .o_prod  (w_fb_prod)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_mix     <= r5_mix;
            r6_echo_st <= r5_echo_st;
            r6_x       <= r5_x;
            r6_mode    <= r5_mode;
            r6_wp      <= r5_wp;
        end
    end

    assign w_store = (r6_mode == MODE_REVERB) ? r6_x + w_fb_prod : r6_echo_st;

    // clamp to plus or minus one
    always_comb begin
        if ($signed(r6_mix) > $signed(UNITY)) begin
            w_clamped = t_out'(OUT_MAX);
        end else if ($signed(r6_mix) < $signed(NEG_UNITY)) begin
            w_clamped = t_out'(OUT_MIN);
        end else begin
            w_clamped = r6_mix[OUT_W-1:0];
        end
    end

    ecrv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_clamped),
        .o_full  (w_q_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_q_data)
    );

    assign o_sample_out = w_q_data;

`ifndef NO_ASSERTIONS
    // pointer moves by one, with wrap, exactly on an input transfer
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_wp == (($past(r_wp) == LAST_ADDR) ? '0
                                                          : $past(r_wp) + t_addr'(1))))
        else $error("write pointer did not advance on input transfer");

    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_wp))
        else $error("write pointer moved without input transfer");

    // once the line has wrapped it stays filled until reset
    a_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |=> r_filled)
        else $error("line-filled flag dropped");

    // a stall freezes the pipeline contents
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v) && $stable(r6_mix) && $stable(r6_wp)))
        else $error("pipeline moved during stall");

    // results always lie within the clamp range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_sample_out) <= OUT_MAX)
                      && ($signed(o_sample_out) >= OUT_MIN)))
        else $error("output sample outside clamp range");
`endif

endmodule

>>> dv/tb_echo_reverb_delay_line.sv
// self-checking testbench for the echo / reverb delay line, with its own line predictor
`timescale 1ns / 1ps

module tb_echo_reverb_delay_line
    import ecrv_pkg::*;
();

    // run limits: slowest legal run is about 1850 items
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 24;
    // chance per transfer of an idle burst, and the burst length range
    localparam int IDLE_PCT    = 12;
    localparam int IDLE_MIN    = 1;
    localparam int IDLE_MAX    = 6;
    // plus and minus one in q16.16
    localparam int ONE_Q       = 1 << FRACTION_BITS;

    // tap distances reduced to the line, nearest tap at index 0
    localparam logic [NUM_TAPS-1:0][ADDR_W-1:0] TAP_BACK = {
        t_addr'(TAP_FOUR_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_THREE_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_TWO_DISTANCE % DELAY_DEPTH),
        t_addr'(TAP_ONE_DISTANCE % DELAY_DEPTH)
    };

    // gain sets for the register phases, echo wet gain at index 0
    localparam logic [6:0][GAIN_W-1:0] GAINS_RESET = {
        RST_REVERB_FB, RST_TAP_FOUR, RST_TAP_THREE, RST_TAP_TWO,
        RST_TAP_ONE, RST_ECHO_FB, RST_ECHO_WET
    };
    localparam logic [6:0][GAIN_W-1:0] GAINS_FULL = {7{16'hFFFF}};
    localparam logic [6:0][GAIN_W-1:0] GAINS_NONE = '0;

    typedef enum logic {STEP_SAMPLE, STEP_REG} t_step_kind;

    // one row of the directed table
    typedef struct {
        t_step_kind kind;
        t_cfg_idx   idx;
        t_cfg_data  data;
        t_sample    sample;
        bit         known;
        t_out       want;
    } t_step;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]  o_sample_out;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_idx                 i_cfg_index = '0;
    t_cfg_data                i_cfg_data = '0;

    // mirror of the delay line, its write pointer and the register file
    t_sample                         line_mirror [DELAY_DEPTH];
    t_addr                           line_wp;
    logic                            cfg_mode;
    t_gain                           wet_gain;
    t_gain                           echo_fb_gain;
    logic [NUM_TAPS-1:0][GAIN_W-1:0] tap_gains;
    t_gain                           reverb_fb_gain;

    // outputs still owed by the block, oldest first
    t_out  pending_outs [$];
    t_step directed_steps [$];

    int    error_count = 0;
    int    cycle_count = 0;
    int    stall_left = 0;
    bit    idling_on = 1'b1;
    t_out  owed_out;

    echo_reverb_delay_line dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_echo_reverb_delay_line: FAIL");
            $finish;
        end
    end

    // sink side back-pressure: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            stall_left  <= $urandom_range(IDLE_MIN, IDLE_MAX) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // output checker: every transfer out must match the oldest owed value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outs.size() == 0) begin
                $display("%0t: output with nothing owed, expected none, got %0d",
                         $time, o_sample_out);
                error_count = error_count + 1;
            end else begin
                owed_out = pending_outs.pop_front();
                if (o_sample_out !== owed_out) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, $signed(owed_out), o_sample_out);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // signed sample times unsigned q0.16 gain, floor shift, low 32 bits kept
    function automatic t_sample scale_by_gain(t_sample v, t_gain g);
        logic signed [48:0] prod;
        prod = $signed(v) * $signed({1'b0, g});
        return prod[47:16];
    endfunction

    // steps the mirror by one sample and returns the clamped output
    function automatic t_out predict_sample_out(t_sample x);
        t_sample dly;
        t_sample mix;
        t_sample result;
        t_sample store;
        t_addr   at;
        if (cfg_mode == MODE_ECHO) begin
            // comb: the entry under the pointer is one full line back
            dly    = line_mirror[line_wp];
            result = x + scale_by_gain(dly, wet_gain);
            store  = x + scale_by_gain(dly, echo_fb_gain);
        end else begin
            mix = x;
            for (int k = 0; k < NUM_TAPS; k++) begin
                at  = line_wp - TAP_BACK[k];
                mix = mix + scale_by_gain(line_mirror[at], tap_gains[k]);
            end
            result = mix;
            store  = x + scale_by_gain(mix, reverb_fb_gain);
        end
        line_mirror[line_wp] = store;
        // depth is a power of two, so the pointer wraps by width
        line_wp = line_wp + 1'b1;
        if ($signed(result) > ONE_Q)
            return t_out'(ONE_Q);
        else if ($signed(result) < -ONE_Q)
            return t_out'(-ONE_Q);
        else
            return result[OUT_W-1:0];
    endfunction

    // mostly audio-range content, with full-range words to force wrapping sums
    function automatic t_sample pick_sample();
        int      sel;
        t_sample s;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            s = t_sample'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        else if (sel < 70)
            s = t_sample'($urandom_range(0, 16 * ONE_Q) - 8 * ONE_Q);
        else if (sel < 85)
            s = t_sample'($urandom);
        else if (sel < 93) begin
            case ($urandom_range(0, 5))
                0: s = 32'h7FFF_FFFF;
                1: s = 32'h8000_0000;
                2: s = t_sample'(ONE_Q);
                3: s = t_sample'(-ONE_Q);
                4: s = t_sample'(ONE_Q + 1);
                default: s = t_sample'(-ONE_Q - 1);
            endcase
        end else
            s = t_sample'($urandom_range(0, 512) - 256);
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_outs.size() != 0)
            @(posedge i_clk);
    endtask

    // one register transfer; the mirror follows only once it is taken
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:      cfg_mode = data[0];
            REG_ECHO_WET:  wet_gain = data;
            REG_ECHO_FB:   echo_fb_gain = data;
            REG_TAP_ONE:   tap_gains[0] = data;
            REG_TAP_TWO:   tap_gains[1] = data;
            REG_TAP_THREE: tap_gains[2] = data;
            REG_TAP_FOUR:  tap_gains[3] = data;
            REG_REVERB_FB: reverb_fb_gain = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one sample transfer; valid is left high so back-to-back items stream
    task automatic send_sample(input t_sample s, input bit known, input t_out want);
        t_out predicted;
        if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(IDLE_MIN, IDLE_MAX)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_sample_out(s);
        pending_outs.push_back(known ? want : predicted);
    endtask

    // drain, load every register, then stream random audio
    task automatic run_phase(input logic mode, input logic [6:0][GAIN_W-1:0] gains,
                             input bit shuffle, input int count, input bit quiet);
        t_cfg_data g;
        int        r;
        i_in_valid <= 1'b0;
        wait_drained();
        idling_on = !quiet;
        // junk in the upper bits of the mode word must be dropped
        g    = t_cfg_data'($urandom);
        g[0] = mode;
        write_reg(REG_MODE, g);
        for (int k = 0; k < 7; k++) begin
            r = $urandom_range(0, 9);
            if (!shuffle)
                g = gains[k];
            else if (r == 0)
                g = '0;
            else if (r == 1)
                g = 16'hFFFF;
            else
                g = t_cfg_data'($urandom_range(0, 65535));
            write_reg(t_cfg_idx'(REG_ECHO_WET + k), g);
        end
        // a write past the register list changes nothing
        write_reg(t_cfg_idx'($urandom_range(REG_REVERB_FB + 1, 255)), t_cfg_data'($urandom));
        repeat (count) send_sample(pick_sample(), 1'b0, '0);
    endtask

    task automatic add_step(input t_step_kind kind, input t_cfg_idx idx,
                            input t_cfg_data data, input t_sample sample,
                            input bit known, input t_out want);
        t_step st;
        st.kind   = kind;
        st.idx    = idx;
        st.data   = data;
        st.sample = sample;
        st.known  = known;
        st.want   = want;
        directed_steps.push_back(st);
    endtask

    initial begin
        // mirror starts from the reset state: empty line, reset gains
        for (int n = 0; n < DELAY_DEPTH; n++)
            line_mirror[n] = '0;
        line_wp        = '0;
        cfg_mode       = MODE_ECHO;
        wet_gain       = RST_ECHO_WET;
        echo_fb_gain   = RST_ECHO_FB;
        tap_gains      = {RST_TAP_FOUR, RST_TAP_THREE, RST_TAP_TWO, RST_TAP_ONE};
        reverb_fb_gain = RST_REVERB_FB;

        // directed table: the line is empty, so early outputs are the clamped input
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_0000, 1'b1, t_out'(0));
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_0001, 1'b1, t_out'(1));
        add_step(STEP_SAMPLE, '0, '0, 32'hFFFF_FFFF, 1'b1, t_out'(-1));
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_ABCD, 1'b1, t_out'(32'h0000_ABCD));
        add_step(STEP_SAMPLE, '0, '0, t_sample'(ONE_Q), 1'b1, t_out'(ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, t_sample'(ONE_Q + 1), 1'b1, t_out'(ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, t_sample'(-ONE_Q), 1'b1, t_out'(-ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, t_sample'(-ONE_Q - 1), 1'b1, t_out'(-ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'h7FFF_FFFF, 1'b1, t_out'(ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'h8000_0000, 1'b1, t_out'(-ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'h5555_5555, 1'b1, t_out'(ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'hAAAA_AAAA, 1'b1, t_out'(-ONE_Q));
        // mode word too wide: low bit clear keeps echo
        add_step(STEP_REG, REG_MODE, 16'hFFFE, '0, 1'b0, '0);
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_8000, 1'b1, t_out'(32'h0000_8000));
        // indexes past the list are dropped
        add_step(STEP_REG, t_cfg_idx'(REG_REVERB_FB + 1), 16'hFFFF, '0, 1'b0, '0);
        add_step(STEP_REG, t_cfg_idx'(255), 16'h0001, '0, 1'b0, '0);
        add_step(STEP_SAMPLE, '0, '0, 32'hFFFF_8000, 1'b1, t_out'(-32768));
        // reverb with every tap still on unwritten entries
        add_step(STEP_REG, REG_MODE, 16'h0001, '0, 1'b0, '0);
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_0064, 1'b1, t_out'(100));
        add_step(STEP_SAMPLE, '0, '0, 32'h7FFF_FFFF, 1'b1, t_out'(ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'h8000_0000, 1'b1, t_out'(-ONE_Q));
        add_step(STEP_SAMPLE, '0, '0, 32'h0000_4000, 1'b0, '0);
        add_step(STEP_SAMPLE, '0, '0, 32'hFFFF_C000, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < directed_steps.size(); n++) begin
            if (directed_steps[n].kind == STEP_REG) begin
                // registers move only with the block idle
                i_in_valid <= 1'b0;
                wait_drained();
                write_reg(directed_steps[n].idx, directed_steps[n].data);
            end else begin
                send_sample(directed_steps[n].sample, directed_steps[n].known,
                            directed_steps[n].want);
            end
        end

        // echo first writes part of the line, so the nearest reverb tap that follows reaches history
        run_phase(MODE_ECHO,   GAINS_RESET, 1'b0, 500, 1'b0);
        run_phase(MODE_REVERB, GAINS_RESET, 1'b0, 400, 1'b0);
        // unity-ish gains: reverb feedback grows until the sums wrap
        run_phase(MODE_ECHO,   GAINS_FULL,  1'b0, 100, 1'b0);
        run_phase(MODE_REVERB, GAINS_FULL,  1'b0, 200, 1'b0);
        run_phase(MODE_REVERB, GAINS_NONE,  1'b0, 100, 1'b0);
        run_phase(MODE_ECHO,   GAINS_NONE,  1'b0, 100, 1'b1);
        run_phase(MODE_REVERB, GAINS_NONE,  1'b1, 150, 1'b0);
        run_phase(MODE_ECHO,   GAINS_NONE,  1'b1, 100, 1'b0);
        // last stretch at full rate, no idling on either side
        run_phase(MODE_REVERB, GAINS_RESET, 1'b0, 100, 1'b1);
        run_phase(MODE_ECHO,   GAINS_NONE,  1'b1, 80,  1'b1);

        i_in_valid <= 1'b0;
        wait_drained();
        // catch any stray transfer out after the last owed one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_echo_reverb_delay_line: PASS");
        else
            $display("tb_echo_reverb_delay_line: FAIL");
        $finish;
    end

endmodule
